[hw/rtl/mme_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the matrix multiply engine.
// Item, result, command and register types; no dependencies.
package mme_pkg;

	localparam int MAX_DIM_DEF    = 8;
	localparam int DATA_WIDTH_DEF = 16;

	localparam int MODE_W    = 2;
	localparam int IDX_W     = 3;
	localparam int ELEM_W    = 16;
	localparam int RES_W     = 35;
	localparam int DIM_W     = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
	localparam logic [MODE_W-1:0] MODE_START  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

	// command queue between front and back, result queue at the output
	localparam int CMD_DEPTH = 2;
	localparam int CMD_PW    = $clog2(CMD_DEPTH);
	localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PW    = $clog2(OUT_DEPTH);
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		logic [MODE_W-1:0]       mode;
		logic [IDX_W-1:0]        row_index;
		logic [IDX_W-1:0]        col_index;
		logic signed [ELEM_W-1:0] elem_value;
	} item_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result_value;
		logic [IDX_W-1:0]        result_row;
		logic [IDX_W-1:0]        result_col;
		logic                    last;
	} res_t;

	typedef struct packed {
		logic [DIM_W-1:0] rows_a;
		logic [DIM_W-1:0] inner_dim;
		logic [DIM_W-1:0] cols_b;
	} dims_t;

	typedef enum logic [1:0] {
		OP_LOAD_A,
		OP_LOAD_B,
		OP_START
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [ELEM_W-1:0] value;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

endpackage

[hw/rtl/mme_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/mme_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input items, drops unused modes and out-of-range loads,
// and queues commands for the back end. Depends on mme_pkg.
module mme_front
	import mme_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t item,
	output cmd_t  cmd,
	output logic  cmd_valid,
	input  logic  cmd_pop
);

	cmd_t              q_q [CMD_DEPTH];
	logic [CMD_PW-1:0] wr_ptr_q;
	logic [CMD_PW-1:0] rd_ptr_q;
	logic [CMD_CW-1:0] cnt_q;

	logic in_range;
	logic keep;
	op_t  op;
	logic push_acc;
	logic enq;
	logic deq;

	assign in_range = ({1'b0, item.row_index} < (IDX_W + 1)'(MAX_DIM)) &&
		({1'b0, item.col_index} < (IDX_W + 1)'(MAX_DIM));

	always_comb begin
		keep = 1'b0;
		op   = OP_START;
		unique case (item.mode)
			MODE_LOAD_A: begin
				keep = in_range;
				op   = OP_LOAD_A;
			end
			MODE_LOAD_B: begin
				keep = in_range;
				op   = OP_LOAD_B;
			end
			MODE_START: begin
				keep = 1'b1;
				op   = OP_START;
			end
			default: keep = 1'b0;
		endcase
	end

	assign full      = (cnt_q == CMD_CW'(CMD_DEPTH));
	assign push_acc  = push && !full;
	assign enq       = push_acc && keep;
	assign cmd_valid = (cnt_q != '0);
	assign deq       = cmd_pop && cmd_valid;
	assign cmd       = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			q_q[wr_ptr_q] <= '{op: op, row: item.row_index, col: item.col_index,
				value: item.elem_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + CMD_PW'(1);
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + CMD_PW'(1);
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + CMD_CW'(1);
			end else if (!enq && deq) begin
				cnt_q <= cnt_q - CMD_CW'(1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CMD_CW'(CMD_DEPTH))
		else $error("command queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cnt_q != '0)
		else $error("command popped from empty queue");

	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		enq && !deq |=> cnt_q == $past(cnt_q) + CMD_CW'(1))
		else $error("queued command lost");

endmodule

[hw/rtl/mme_back.sv]
`timescale 1ns / 1ps
// Back end: writes loads into the A and B RAMs, sequences the product over
// rows, columns and the inner dimension through a MAC pipeline, and queues
// results. Depends on mme_pkg and mme_ram.
module mme_back
	import mme_pkg::*;
#(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	input  logic  cmd_valid,
	output logic  cmd_pop,
	input  dims_t dims,
	output res_t  result,
	output logic  empty,
	input  logic  pop
);

	localparam int AW = $clog2(MAX_DIM * MAX_DIM);
	localparam int IW = $clog2(MAX_DIM);
	localparam int CW = $clog2(MAX_DIM + 1);
	localparam int DW = DATA_WIDTH;

	back_state_t state_q, state_d;
	logic [IW-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
	logic [CW-1:0] nr_q, nr_d, nk_q, nk_d, nc_q, nc_d;
	logic [CW-1:0] nr_cl, nk_cl, nc_cl;

	logic          issue;
	logic          last_k, last_c, last_r;
	logic          credit_ok;
	logic          we_a, we_b;
	logic [AW-1:0] waddr, raddr_a, raddr_b;
	logic [DW-1:0] wdata, rdata_a, rdata_b;

	logic          v_s1, first_s1, lastk_s1, zero_s1, lastel_s1;
	logic [IW-1:0] row_s1, col_s1;
	logic          v_s2, first_s2, lastk_s2, lastel_s2;
	logic [IW-1:0] row_s2, col_s2;
	logic signed [RES_W-1:0] prod_s2;
	logic signed [RES_W-1:0] acc_q;
	logic signed [RES_W-1:0] sum;

	logic signed [DW-1:0]   a_s, b_s;
	logic signed [2*DW-1:0] prod_full;

	res_t              fifo_q [OUT_DEPTH];
	logic [OUT_PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OUT_CW-1:0] fifo_cnt_q, pend_q;
	logic              res_push, res_pop;

	assign nr_cl = (dims.rows_a > DIM_W'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(dims.rows_a);
	assign nk_cl = (dims.inner_dim > DIM_W'(MAX_DIM)) ? CW'(MAX_DIM) :
		CW'(dims.inner_dim);
	assign nc_cl = (dims.cols_b > DIM_W'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(dims.cols_b);

	// zero inner dimension: one pass per element with the product forced to zero
	assign last_k = (nk_q == '0) || (CW'(k_q) + CW'(1) == nk_q);
	assign last_c = (CW'(c_q) + CW'(1) == nc_q);
	assign last_r = (CW'(r_q) + CW'(1) == nr_q);

	// reserve a result slot before the first beat of each element
	assign credit_ok = ((OUT_CW + 1)'(fifo_cnt_q) + (OUT_CW + 1)'(pend_q)) <
		(OUT_CW + 1)'(OUT_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
			nr_q    <= '0;
			nk_q    <= '0;
			nc_q    <= '0;
		end else begin
			state_q <= state_d;
			r_q     <= r_d;
			c_q     <= c_d;
			k_q     <= k_d;
			nr_q    <= nr_d;
			nk_q    <= nk_d;
			nc_q    <= nc_d;
		end
	end

	always_comb begin
		state_d = state_q;
		r_d     = r_q;
		c_d     = c_q;
		k_d     = k_q;
		nr_d    = nr_q;
		nk_d    = nk_q;
		nc_d    = nc_q;
		cmd_pop = 1'b0;
		we_a    = 1'b0;
		we_b    = 1'b0;
		issue   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						OP_LOAD_A: we_a = 1'b1;
						OP_LOAD_B: we_b = 1'b1;
						OP_START: begin
							nr_d = nr_cl;
							nk_d = nk_cl;
							nc_d = nc_cl;
							r_d  = '0;
							c_d  = '0;
							k_d  = '0;
							if (nr_cl != '0 && nc_cl != '0) begin
								state_d = BK_RUN;
							end
						end
						default: cmd_pop = 1'b1;
					endcase
				end
			end
			BK_RUN: begin
				issue = (k_q != '0) || credit_ok;
				if (issue) begin
					if (last_k) begin
						k_d = '0;
						if (last_c) begin
							c_d = '0;
							if (last_r) begin
								state_d = BK_IDLE;
							end else begin
								r_d = r_q + IW'(1);
							end
						end else begin
							c_d = c_q + IW'(1);
						end
					end else begin
						k_d = k_q + IW'(1);
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign waddr   = AW'(cmd.row) * AW'(MAX_DIM) + AW'(cmd.col);
	assign wdata   = DW'(cmd.value);
	assign raddr_a = AW'(r_q) * AW'(MAX_DIM) + AW'(k_q);
	assign raddr_b = AW'(k_q) * AW'(MAX_DIM) + AW'(c_q);

	mme_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_DIM * MAX_DIM)
	) u_ram_a (
		.clk  (clk),
		.we   (we_a),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr_a),
		.rdata(rdata_a)
	);

	mme_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_DIM * MAX_DIM)
	) u_ram_b (
		.clk  (clk),
		.we   (we_b),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr_b),
		.rdata(rdata_b)
	);

	// stage 1: RAM read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1  <= (k_q == '0);
		lastk_s1  <= last_k;
		zero_s1   <= (nk_q == '0);
		lastel_s1 <= last_r && last_c;
		row_s1    <= r_q;
		col_s1    <= c_q;
	end

	// stage 2: product
	assign a_s       = $signed(rdata_a);
	assign b_s       = $signed(rdata_b);
	assign prod_full = a_s * b_s;

	always_ff @(posedge clk) begin
		first_s2  <= first_s1;
		lastk_s2  <= lastk_s1;
		lastel_s2 <= lastel_s1;
		row_s2    <= row_s1;
		col_s2    <= col_s1;
		prod_s2   <= zero_s1 ? '0 : RES_W'(prod_full);
	end

	// stage 3: accumulate, push on the last inner beat
	assign sum      = (first_s2 ? '0 : acc_q) + prod_s2;
	assign res_push = v_s2 && lastk_s2;

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= sum;
		end
		if (res_push) begin
			fifo_q[wr_ptr_q] <= '{result_value: sum, result_row: IDX_W'(row_s2),
				result_col: IDX_W'(col_s2), last: lastel_s2};
		end
	end

	assign empty   = (fifo_cnt_q == '0);
	assign res_pop = pop && !empty;
	assign result  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			pend_q     <= '0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= wr_ptr_q + OUT_PW'(1);
			end
			if (res_pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PW'(1);
			end
			if (res_push && !res_pop) begin
				fifo_cnt_q <= fifo_cnt_q + OUT_CW'(1);
			end else if (!res_push && res_pop) begin
				fifo_cnt_q <= fifo_cnt_q - OUT_CW'(1);
			end
			if ((issue && k_q == '0) && !res_push) begin
				pend_q <= pend_q + OUT_CW'(1);
			end else if (!(issue && k_q == '0) && res_push) begin
				pend_q <= pend_q - OUT_CW'(1);
			end
		end
	end

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((OUT_CW + 1)'(fifo_cnt_q) + (OUT_CW + 1)'(pend_q)) <=
		(OUT_CW + 1)'(OUT_DEPTH))
		else $error("result slots over-reserved");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> fifo_cnt_q < OUT_CW'(OUT_DEPTH) && pend_q != '0)
		else $error("result pushed without a reserved slot");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> state_q == BK_IDLE && !issue)
		else $error("command taken while a product runs");

endmodule

[hw/rtl/matrix_multiply_engine_core.sv]
`timescale 1ns / 1ps
// Top level of the matrix multiply engine: configuration registers, front end
// and back end. Depends on mme_pkg, mme_front and mme_back.
//
// Usage:
//   Input queue: drive item and push; a beat is taken when push is high and
//   full is low. Mode 0 loads an A element, mode 1 a B element (either is
//   ignored if row or column is not below MAX_DIM), mode 2 starts C = A x B,
//   mode 3 is dropped. Loads are taken at one per cycle while full is low.
//   Result queue: while empty is low, result holds the oldest element of C;
//   pop takes it. Elements come in row-major order, last marks the final one.
//   Configuration: cfg_index selects rows_a, inner_dim or cols_b, written
//   with cfg_data on cfg_valid (cfg_ready is always high); write only while
//   no product is pending. Values above MAX_DIM act as MAX_DIM.
//   Timing: a start leaves the command queue while the back end is idle, then
//   runs rows x cols x max(1, inner) beats, one multiply-accumulate beat per
//   cycle on the shared MAC pipeline while a result slot can be reserved. Each
//   result passes the RAM read, product and accumulate stages before it is queued.
//   Reset clears the dimensions to 1 and empties both queues; A and B hold
//   garbage until written. When the receiver stalls, the four-entry result
//   queue fills and the sequencer waits at the next element boundary; the
//   two-entry command queue then fills and full rises.
module matrix_multiply_engine_core
	import mme_pkg::*;
#(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  item_t                item,
	output logic                 empty,
	input  logic                 pop,
	output res_t                 result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	dims_t dims_q;
	cmd_t  cmd;
	logic  cmd_valid;
	logic  cmd_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= '{rows_a: DIM_W'(1), inner_dim: DIM_W'(1), cols_b: DIM_W'(1)};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROWS_A:    dims_q.rows_a    <= cfg_data;
				REG_INNER_DIM: dims_q.inner_dim <= cfg_data;
				REG_COLS_B:    dims_q.cols_b    <= cfg_data;
				default:       dims_q           <= dims_q;
			endcase
		end
	end

	mme_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop)
	);

	mme_back #(
		.MAX_DIM   (MAX_DIM),
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.dims     (dims_q),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

[tb/matrix_multiply_engine_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for matrix_multiply_engine_core: element loads, product starts and
// dimension writes, checked against a behavioral C = A x B scoreboard.
// Depends on mme_pkg and the engine RTL.
module matrix_multiply_engine_core_tb;
	import mme_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int ITEM_GOAL   = 320;
	localparam int SETTLE_CYC  = 24;
	localparam int PHASE_ITEMS = 30;

	// Behavioral product engine plus the queue of product elements still owed.
	class product_checker;
		logic signed [ELEM_W-1:0] mat_a [MAX_DIM_DEF][MAX_DIM_DEF];
		logic signed [ELEM_W-1:0] mat_b [MAX_DIM_DEF][MAX_DIM_DEF];
		dims_t dims = {4'd1, 4'd1, 4'd1};
		res_t pending_elems [$];
		int errors = 0;

		function int clamp_dim(logic [DIM_W-1:0] d);
			return (d > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(d);
		endfunction

		function int pending();
			return pending_elems.size();
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
			case (idx)
				REG_ROWS_A: dims.rows_a = val;
				REG_INNER_DIM: dims.inner_dim = val;
				REG_COLS_B: dims.cols_b = val;
				default: ;
			endcase
		endfunction

		function void take_item(item_t it);
			int nr, nk, nc, r, c, k;
			longint acc;
			res_t elem;
			case (it.mode)
				MODE_LOAD_A: mat_a[it.row_index][it.col_index] = it.elem_value;
				MODE_LOAD_B: mat_b[it.row_index][it.col_index] = it.elem_value;
				MODE_START: begin
					nr = clamp_dim(dims.rows_a);
					nk = clamp_dim(dims.inner_dim);
					nc = clamp_dim(dims.cols_b);
					for (r = 0; r < nr; r++) begin
						for (c = 0; c < nc; c++) begin
							acc = 0;
							for (k = 0; k < nk; k++)
								acc += longint'(mat_a[r][k]) * longint'(mat_b[k][c]);
							elem.result_value = acc[RES_W-1:0];
							elem.result_row = IDX_W'(r);
							elem.result_col = IDX_W'(c);
							elem.last = (r == nr - 1) && (c == nc - 1);
							pending_elems.push_back(elem);
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void flag(string name, logic signed [63:0] want, logic signed [63:0] got);
			errors++;
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		endfunction

		function void check_elem(res_t got);
			res_t want;
			if (pending_elems.size() == 0) begin
				errors++;
				$display("%0t unexpected beat: expected none, actual value %0d row %0d col %0d last %0d",
					$time, got.result_value, got.result_row, got.result_col, got.last);
				return;
			end
			want = pending_elems.pop_front();
			if (got.result_value !== want.result_value)
				flag("result_value", want.result_value, got.result_value);
			if (got.result_row !== want.result_row)
				flag("result_row", want.result_row, got.result_row);
			if (got.result_col !== want.result_col)
				flag("result_col", want.result_col, got.result_col);
			if (got.last !== want.last)
				flag("last", want.last, got.last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	item_t item = '0;
	logic empty;
	logic pop = 1'b0;
	res_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_data = '0;

	product_checker sb = new;
	bit a_loaded [MAX_DIM_DEF][MAX_DIM_DEF];
	bit b_loaded [MAX_DIM_DEF][MAX_DIM_DEF];
	int item_count = 0;
	int send_idle = 0;
	int pop_stall = 0;

	matrix_multiply_engine_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= pop_stall);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_elem(result);
	end

	// Hold push high after a beat; the next send or settle decides what follows.
	task automatic send_item(item_t it);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		sb.take_item(it);
		if (it.mode != MODE_UNUSED)
			item_count++;
	endtask

	task automatic send_op(logic [MODE_W-1:0] m);
		item_t it;
		it.mode = m;
		it.row_index = IDX_W'($urandom);
		it.col_index = IDX_W'($urandom);
		it.elem_value = ELEM_W'($urandom);
		send_item(it);
	endtask

	task automatic load_elem(logic [MODE_W-1:0] m, int r, int c, logic signed [ELEM_W-1:0] v);
		item_t it;
		it.mode = m;
		it.row_index = IDX_W'(r);
		it.col_index = IDX_W'(c);
		it.elem_value = v;
		send_item(it);
		if (m == MODE_LOAD_A)
			a_loaded[r][c] = 1'b1;
		else
			b_loaded[r][c] = 1'b1;
	endtask

	// Drop push, drain every owed element, then let the back end go quiet.
	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_dims(logic [DIM_W-1:0] nr, logic [DIM_W-1:0] nk, logic [DIM_W-1:0] nc);
		logic [DIM_W-1:0] vals [3];
		logic [CFG_IDX_W-1:0] regs [3];
		vals = '{nr, nk, nc};
		regs = '{REG_ROWS_A, REG_INNER_DIM, REG_COLS_B};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(regs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [ELEM_W-1:0] rand_elem();
		case ($urandom_range(9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return '0;
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	function automatic bit operands_ready();
		int nr, nk, nc;
		nr = sb.clamp_dim(sb.dims.rows_a);
		nk = sb.clamp_dim(sb.dims.inner_dim);
		nc = sb.clamp_dim(sb.dims.cols_b);
		for (int r = 0; r < nr; r++)
			for (int k = 0; k < nk; k++)
				if (!a_loaded[r][k])
					return 1'b0;
		for (int k = 0; k < nk; k++)
			for (int c = 0; c < nc; c++)
				if (!b_loaded[k][c])
					return 1'b0;
		return 1'b1;
	endfunction

	// Refresh part of the operands (all of any never loaded), then start, at times after an unused item.
	task automatic product_job();
		int nr, nk, nc;
		nr = sb.clamp_dim(sb.dims.rows_a);
		nk = sb.clamp_dim(sb.dims.inner_dim);
		nc = sb.clamp_dim(sb.dims.cols_b);
		for (int r = 0; r < nr; r++)
			for (int k = 0; k < nk; k++)
				if (!a_loaded[r][k] || $urandom_range(99) < 40)
					load_elem(MODE_LOAD_A, r, k, rand_elem());
		for (int k = 0; k < nk; k++)
			for (int c = 0; c < nc; c++)
				if (!b_loaded[k][c] || $urandom_range(99) < 40)
					load_elem(MODE_LOAD_B, k, c, rand_elem());
		if ($urandom_range(9) == 0)
			send_op(MODE_UNUSED);
		send_op(MODE_START);
	endtask

	task automatic noise_job();
		case ($urandom_range(3))
			0: load_elem(MODE_LOAD_A, $urandom_range(7), $urandom_range(7), rand_elem());
			1: load_elem(MODE_LOAD_B, $urandom_range(7), $urandom_range(7), rand_elem());
			2: send_op(MODE_UNUSED);
			default: begin
				if (operands_ready())
					send_op(MODE_START);
				else
					load_elem(MODE_LOAD_B, $urandom_range(7), $urandom_range(7), rand_elem());
			end
		endcase
	endtask

	initial begin
		int phase_end;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset dimensions are 1 x 1 x 1: extremes of the elements.
		load_elem(MODE_LOAD_A, 0, 0, 16'sh7fff);
		load_elem(MODE_LOAD_B, 0, 0, 16'sh7fff);
		send_op(MODE_START);
		load_elem(MODE_LOAD_A, 0, 0, 16'sh8000);
		load_elem(MODE_LOAD_B, 0, 0, 16'sh8000);
		send_op(MODE_START);
		load_elem(MODE_LOAD_B, 0, 0, 16'sh7fff);
		send_op(MODE_START);
		send_op(MODE_UNUSED);
		load_elem(MODE_LOAD_A, 7, 7, 16'sh8000);
		load_elem(MODE_LOAD_B, 7, 7, 16'sh7fff);
		settle();
		// Zero rows, zero inner (all-zero elements) and zero columns.
		write_dims(4'd0, 4'd1, 4'd1);
		send_op(MODE_START);
		settle();
		write_dims(4'd1, 4'd0, 4'd2);
		send_op(MODE_START);
		settle();
		write_dims(4'd1, 4'd1, 4'd0);
		send_op(MODE_START);

		for (int p = 0; item_count < ITEM_GOAL; p++) begin
			settle();
			case (p % 4)
				0: begin send_idle = 0; pop_stall = 0; end
				1: begin send_idle = 56; pop_stall = 0; end
				2: begin send_idle = 0; pop_stall = 56; end
				default: begin send_idle = 13; pop_stall = 13; end
			endcase
			case (p)
				1: write_dims(4'd8, 4'd8, 4'd8);
				2: write_dims(4'd15, 4'd9, 4'd12);
				3: write_dims(4'd0, DIM_W'($urandom_range(1, 8)), DIM_W'($urandom_range(1, 8)));
				4: write_dims(DIM_W'($urandom_range(1, 3)), 4'd0, DIM_W'($urandom_range(1, 3)));
				default: write_dims(DIM_W'($urandom_range(1, 3)), DIM_W'($urandom_range(1, 4)),
					DIM_W'($urandom_range(1, 3)));
			endcase
			phase_end = item_count + PHASE_ITEMS;
			while (item_count < phase_end) begin
				if ($urandom_range(99) < 80)
					product_job();
				else
					noise_job();
			end
		end

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
